// ----- hdl/awds_pkg.sv -----
package awds_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int WDAY_W  = 3;

    localparam logic [12:0] DIV100_MUL = 13'd5243;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    localparam logic [WDAY_W-1:0] WD_MON = 3'd1;
    localparam logic [WDAY_W-1:0] WD_FRI = 3'd5;
    localparam logic [WDAY_W-1:0] WD_SAT = 3'd6;
    localparam logic [WDAY_W-1:0] WD_SUN = 3'd7;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } date_t;

    typedef struct packed {
        date_t      date;
        logic       back;
        logic [7:0] q100;
    } entry_t;

    typedef struct packed {
        logic        valid;
        date_t       date;
        logic        back;
        logic        leap;
        logic [15:0] wsum;
    } prep_t;

    typedef struct packed {
        logic              valid;
        date_t             date;
        logic              back;
        logic              leap;
        logic [1:0]        nsteps;
        logic [WDAY_W-1:0] wday;
    } plan_t;

    function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
        logic [DAY_W-1:0] d;
        case (m)
            4'd2:                   d = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
            default:                d = 5'd31;
        endcase
        return d;
    endfunction

    // (2m + 3(m+1)/5) mod 7, january and february as months 13 and 14
    function automatic logic [2:0] month_offset(input logic [MONTH_W-1:0] m);
        logic [2:0] o;
        case (m)
            4'd1:    o = 3'd6;
            4'd2:    o = 3'd2;
            4'd3:    o = 3'd1;
            4'd4:    o = 3'd4;
            4'd5:    o = 3'd6;
            4'd6:    o = 3'd2;
            4'd7:    o = 3'd4;
            4'd8:    o = 3'd0;
            4'd9:    o = 3'd3;
            4'd10:   o = 3'd5;
            4'd11:   o = 3'd1;
            default: o = 3'd3;
        endcase
        return o;
    endfunction

endpackage

// ----- hdl/awds_prep.sv -----
module awds_prep (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    input  logic [awds_pkg::YEAR_W-1:0]     year,
    input  logic [awds_pkg::MONTH_W-1:0]    month,
    input  logic [awds_pkg::DAY_W-1:0]      day,
    input  logic                            back,
    output awds_pkg::prep_t                 prep
);

    awds_pkg::entry_t                  entry_next;
    awds_pkg::entry_t                  entry_reg;
    logic                              valid_a_reg;
    logic [26:0]                       product;

    logic [6:0]                        r100;
    logic                              leap;
    logic [awds_pkg::DAY_W-1:0]        dim;
    logic [awds_pkg::DAY_W-1:0]        day_c;
    logic                              early;
    logic [awds_pkg::YEAR_W-1:0]       ya;
    logic [7:0]                        qa;
    logic [14:0]                       yb;
    logic [7:0]                        qb;
    logic [15:0]                       wsum;

    awds_pkg::prep_t                   prep_next;
    awds_pkg::prep_t                   prep_reg;
    logic                              valid_b_reg;

    // input clamping and year / 100 by reciprocal
    always_comb
    begin
        entry_next.date.year  = (year == '0) ? 14'd1 : year;
        entry_next.date.month = (month == '0) ? awds_pkg::MONTH_JAN :
                                (month > awds_pkg::MONTH_DEC) ? awds_pkg::MONTH_DEC : month;
        entry_next.date.day   = (day == '0) ? 5'd1 : day;
        entry_next.back       = back;
        product               = 27'(entry_next.date.year) * 27'(awds_pkg::DIV100_MUL);
        entry_next.q100       = product[26:19];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
        end
        else
        begin
            valid_a_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    // leap rule, day clamp, weekday sum
    always_comb
    begin
        r100  = 7'(entry_reg.date.year - 14'(entry_reg.q100) * 14'd100);
        leap  = ((entry_reg.date.year[1:0] == 2'b00) && (r100 != 7'd0)) ||
                ((r100 == 7'd0) && (entry_reg.q100[1:0] == 2'b00));
        dim   = awds_pkg::days_in(entry_reg.date.month, leap);
        day_c = (entry_reg.date.day > dim) ? dim : entry_reg.date.day;
        early = (entry_reg.date.month <= awds_pkg::MONTH_FEB);
        ya    = early ? entry_reg.date.year - 14'd1 : entry_reg.date.year;
        qa    = (early && (r100 == 7'd0)) ? entry_reg.q100 - 8'd1 : entry_reg.q100;
        yb    = 15'(ya) + 15'd400;
        qb    = qa + 8'd4;
        wsum  = 16'(day_c) + 16'(awds_pkg::month_offset(entry_reg.date.month))
              + 16'(yb) + 16'(yb >> 2) - 16'(qb) + 16'(qb >> 2);

        prep_next.valid      = valid_a_reg;
        prep_next.date.year  = entry_reg.date.year;
        prep_next.date.month = entry_reg.date.month;
        prep_next.date.day   = day_c;
        prep_next.back       = entry_reg.back;
        prep_next.leap       = leap;
        prep_next.wsum       = wsum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_b_reg <= 1'b0;
        end
        else
        begin
            valid_b_reg <= valid_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prep_reg <= prep_next;
    end

    always_comb
    begin
        prep       = prep_reg;
        prep.valid = valid_b_reg;
    end

endmodule

// ----- hdl/awds_wday.sv -----
module awds_wday (
    input  logic             clk,
    input  logic             rst_n,
    input  awds_pkg::prep_t  prep,
    output awds_pkg::plan_t  plan
);

    logic [5:0]                       fold1;
    logic [3:0]                       fold2;
    logic [2:0]                       rem7;
    logic [awds_pkg::WDAY_W-1:0]      w0;
    awds_pkg::plan_t                  plan_next;
    awds_pkg::plan_t                  plan_reg;
    logic                             valid_reg;

    // mod 7 by octal digit folding, then weekend skip count
    always_comb
    begin
        fold1 = 6'(prep.wsum[2:0]) + 6'(prep.wsum[5:3]) + 6'(prep.wsum[8:6])
              + 6'(prep.wsum[11:9]) + 6'(prep.wsum[14:12]) + 6'(prep.wsum[15]);
        fold2 = 4'(fold1[2:0]) + 4'(fold1[5:3]);
        rem7  = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];
        w0    = rem7 + 3'd1;

        plan_next.valid = prep.valid;
        plan_next.date  = prep.date;
        plan_next.back  = prep.back;
        plan_next.leap  = prep.leap;
        if (prep.back)
        begin
            if (w0 == awds_pkg::WD_MON)
            begin
                plan_next.nsteps = 2'd3;
                plan_next.wday   = awds_pkg::WD_FRI;
            end
            else if (w0 == awds_pkg::WD_SUN)
            begin
                plan_next.nsteps = 2'd2;
                plan_next.wday   = awds_pkg::WD_FRI;
            end
            else
            begin
                plan_next.nsteps = 2'd1;
                plan_next.wday   = w0 - 3'd1;
            end
        end
        else
        begin
            if (w0 == awds_pkg::WD_FRI)
            begin
                plan_next.nsteps = 2'd3;
                plan_next.wday   = awds_pkg::WD_MON;
            end
            else if (w0 == awds_pkg::WD_SAT)
            begin
                plan_next.nsteps = 2'd2;
                plan_next.wday   = awds_pkg::WD_MON;
            end
            else if (w0 == awds_pkg::WD_SUN)
            begin
                plan_next.nsteps = 2'd1;
                plan_next.wday   = awds_pkg::WD_MON;
            end
            else
            begin
                plan_next.nsteps = 2'd1;
                plan_next.wday   = w0 + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= prep.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        plan_reg <= plan_next;
    end

    always_comb
    begin
        plan       = plan_reg;
        plan.valid = valid_reg;
    end

endmodule

// ----- hdl/awds_step.sv -----
module awds_step (
    input  logic                            clk,
    input  logic                            rst_n,
    input  awds_pkg::plan_t                 plan,
    output logic                            done,
    output logic [awds_pkg::YEAR_W-1:0]     found_year,
    output logic [awds_pkg::MONTH_W-1:0]    found_month,
    output logic [awds_pkg::DAY_W-1:0]      found_day,
    output logic [awds_pkg::WDAY_W-1:0]     weekday_number
);

    logic [awds_pkg::DAY_W-1:0]      dim;
    logic [awds_pkg::DAY_W-1:0]      dim_prev;
    logic [5:0]                      day_fwd;
    logic [awds_pkg::MONTH_W-1:0]    month_prev;
    awds_pkg::date_t                 date_next;
    awds_pkg::date_t                 date_reg;
    logic [awds_pkg::WDAY_W-1:0]     wday_reg;
    logic                            done_reg;

    // move the date by one to three days with at most one month rollover
    always_comb
    begin
        dim        = awds_pkg::days_in(plan.date.month, plan.leap);
        month_prev = plan.date.month - 4'd1;
        dim_prev   = awds_pkg::days_in(month_prev, plan.leap);
        day_fwd    = 6'(plan.date.day) + 6'(plan.nsteps);
        date_next  = plan.date;
        if (plan.back)
        begin
            if (plan.date.day > 5'(plan.nsteps))
            begin
                date_next.day = plan.date.day - 5'(plan.nsteps);
            end
            else if (plan.date.month == awds_pkg::MONTH_JAN)
            begin
                date_next.year  = plan.date.year - 14'd1;
                date_next.month = awds_pkg::MONTH_DEC;
                date_next.day   = 5'd31 + plan.date.day - 5'(plan.nsteps);
            end
            else
            begin
                date_next.month = month_prev;
                date_next.day   = dim_prev + plan.date.day - 5'(plan.nsteps);
            end
        end
        else
        begin
            if (day_fwd <= 6'(dim))
            begin
                date_next.day = 5'(day_fwd);
            end
            else
            begin
                date_next.day = 5'(day_fwd - 6'(dim));
                if (plan.date.month == awds_pkg::MONTH_DEC)
                begin
                    date_next.month = awds_pkg::MONTH_JAN;
                    date_next.year  = plan.date.year + 14'd1;
                end
                else
                begin
                    date_next.month = plan.date.month + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= plan.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        date_reg <= date_next;
        wday_reg <= plan.wday;
    end

    assign done           = done_reg;
    assign found_year     = date_reg.year;
    assign found_month    = date_reg.month;
    assign found_day      = date_reg.day;
    assign weekday_number = wday_reg;

endmodule

// ----- hdl/adjacent_weekday_date_stepper.sv -----
// a start transfer passes valid_a_reg and valid_b_reg, then valid_reg, then done_reg, which drives done
// throughput: one transfer per cycle, busy stays low
// pipeline: input clamp and divide by 100, leap and weekday sum, mod 7, day step
// the receiver cannot stall, each result shows for one cycle with done
// reset: rst_n low clears every valid bit at once, items in flight are dropped
module adjacent_weekday_date_stepper (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [awds_pkg::YEAR_W-1:0]     start_year,
    input  logic [awds_pkg::MONTH_W-1:0]    start_month,
    input  logic [awds_pkg::DAY_W-1:0]      start_day,
    input  logic                            step_back,
    output logic                            done,
    output logic [awds_pkg::YEAR_W-1:0]     found_year,
    output logic [awds_pkg::MONTH_W-1:0]    found_month,
    output logic [awds_pkg::DAY_W-1:0]      found_day,
    output logic [awds_pkg::WDAY_W-1:0]     weekday_number
);

    awds_pkg::prep_t   prep;
    awds_pkg::plan_t   plan;
    logic              transfer;

    assign busy     = 1'b0;
    assign transfer = start && !busy;

    awds_prep u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (transfer),
        .year       (start_year),
        .month      (start_month),
        .day        (start_day),
        .back       (step_back),
        .prep       (prep)
    );

    awds_wday u_wday (
        .clk   (clk),
        .rst_n (rst_n),
        .prep  (prep),
        .plan  (plan)
    );

    awds_step u_step (
        .clk            (clk),
        .rst_n          (rst_n),
        .plan           (plan),
        .done           (done),
        .found_year     (found_year),
        .found_month    (found_month),
        .found_day      (found_day),
        .weekday_number (weekday_number)
    );

endmodule

// ----- hdl/awds_checker.sv -----
module awds_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            start,
    input logic                            busy,
    input logic                            done,
    input logic [awds_pkg::YEAR_W-1:0]     found_year,
    input logic [awds_pkg::MONTH_W-1:0]    found_month,
    input logic [awds_pkg::DAY_W-1:0]      found_day,
    input logic [awds_pkg::WDAY_W-1:0]     weekday_number
);

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##4 done)
        else $error("transfer without result four cycles later");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##4 !done)
        else $error("result without matching transfer");

    a_weekday_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (weekday_number >= awds_pkg::WD_MON) && (weekday_number <= awds_pkg::WD_FRI))
        else $error("weekday outside monday to friday");

    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (found_month >= awds_pkg::MONTH_JAN) && (found_month <= awds_pkg::MONTH_DEC)
                 && (found_day != '0))
        else $error("result date out of range");

    a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$isunknown({found_year, found_month, found_day, weekday_number}))
        else $error("result with unknown bits");

endmodule

bind adjacent_weekday_date_stepper awds_checker u_awds_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .done           (done),
    .found_year     (found_year),
    .found_month    (found_month),
    .found_day      (found_day),
    .weekday_number (weekday_number)
);

// ----- tb/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        awds_pkg::date_t             date;
        logic [awds_pkg::WDAY_W-1:0] wday;
    } business_day_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic [awds_pkg::YEAR_W-1:0]   start_year = '0;
    logic [awds_pkg::MONTH_W-1:0]  start_month = '0;
    logic [awds_pkg::DAY_W-1:0]    start_day = '0;
    logic                          step_back = 1'b0;
    logic                          done;
    logic [awds_pkg::YEAR_W-1:0]   found_year;
    logic [awds_pkg::MONTH_W-1:0]  found_month;
    logic [awds_pkg::DAY_W-1:0]    found_day;
    logic [awds_pkg::WDAY_W-1:0]   weekday_number;

    business_day_t pending_days[$];
    int            mismatch_count = 0;
    bit            idle_on = 1'b1;

    always #5 clk = ~clk;

    adjacent_weekday_date_stepper DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .start_year     (start_year),
        .start_month    (start_month),
        .start_day      (start_day),
        .step_back      (step_back),
        .done           (done),
        .found_year     (found_year),
        .found_month    (found_month),
        .found_day      (found_day),
        .weekday_number (weekday_number)
    );

    function automatic bit is_leap(input int unsigned y);
        return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
        if (m == awds_pkg::MONTH_FEB)
            return is_leap(y) ? 29 : 28;
        if (m == 4 || m == 6 || m == 9 || m == 11)
            return 30;
        return 31;
    endfunction

    // 1 monday .. 7 sunday, shifted by 400 years to keep the year positive
    function automatic int unsigned zeller_weekday(input int unsigned y, input int unsigned m,
                                                   input int unsigned d);
        int unsigned yy;
        int unsigned mm;
        yy = y + 400;
        mm = m;
        if (mm <= awds_pkg::MONTH_FEB)
        begin
            mm = mm + 12;
            yy = yy - 1;
        end
        return (d + 2 * mm + (3 * (mm + 1)) / 5 + yy + yy / 4 - yy / 100 + yy / 400) % 7 + 1;
    endfunction

    function automatic business_day_t next_business_day(
        input logic [awds_pkg::YEAR_W-1:0]  in_year,
        input logic [awds_pkg::MONTH_W-1:0] in_month,
        input logic [awds_pkg::DAY_W-1:0]   in_day,
        input logic                         back);
        int unsigned   y;
        int unsigned   m;
        int unsigned   d;
        int unsigned   w;
        business_day_t r;
        y = 32'(in_year);
        m = 32'(in_month);
        d = 32'(in_day);
        w = 32'(awds_pkg::WD_SAT);
        if (y == 0)
            y = 1;
        if (m == 0)
            m = 32'(awds_pkg::MONTH_JAN);
        if (m > awds_pkg::MONTH_DEC)
            m = 32'(awds_pkg::MONTH_DEC);
        if (d == 0)
            d = 1;
        if (d > month_length(y, m))
            d = month_length(y, m);
        for (int guard = 0; guard < 7 && w > awds_pkg::WD_FRI; guard++)
        begin
            if (back)
            begin
                if (d > 1)
                    d = d - 1;
                else if (m > awds_pkg::MONTH_JAN)
                begin
                    m = m - 1;
                    d = month_length(y, m);
                end
                else
                begin
                    y = y - 1;
                    m = 32'(awds_pkg::MONTH_DEC);
                    d = 31;
                end
            end
            else
            begin
                if (d < month_length(y, m))
                    d = d + 1;
                else
                begin
                    d = 1;
                    if (m < awds_pkg::MONTH_DEC)
                        m = m + 1;
                    else
                    begin
                        m = 32'(awds_pkg::MONTH_JAN);
                        y = y + 1;
                    end
                end
            end
            w = zeller_weekday(y, m, d);
        end
        r.date.year  = y[awds_pkg::YEAR_W-1:0];
        r.date.month = m[awds_pkg::MONTH_W-1:0];
        r.date.day   = d[awds_pkg::DAY_W-1:0];
        r.wday       = w[awds_pkg::WDAY_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        business_day_t want;
        if (rst_n && done)
        begin
            if (pending_days.size() == 0)
                report_mismatch("unexpected result", 32'(found_year), 0);
            else
            begin
                want = pending_days.pop_front();
                if (found_year !== want.date.year)
                    report_mismatch("found_year", 32'(found_year), 32'(want.date.year));
                if (found_month !== want.date.month)
                    report_mismatch("found_month", 32'(found_month), 32'(want.date.month));
                if (found_day !== want.date.day)
                    report_mismatch("found_day", 32'(found_day), 32'(want.date.day));
                if (weekday_number !== want.wday)
                    report_mismatch("weekday_number", 32'(weekday_number), 32'(want.wday));
            end
        end
    end

    task automatic send_date(input logic [awds_pkg::YEAR_W-1:0] y,
                             input logic [awds_pkg::MONTH_W-1:0] m,
                             input logic [awds_pkg::DAY_W-1:0] d, input logic back);
        start       <= 1'b1;
        start_year  <= y;
        start_month <= m;
        start_day   <= d;
        step_back   <= back;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_days.insert(pending_days.size(), next_business_day(y, m, d, back));
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 7))
                @(posedge clk);
        end
    endtask

    task automatic test_calendar_edges();
        send_date(14'd2024, 4'd2, 5'd28, 1'b0);
        send_date(14'd2024, 4'd3, 5'd1, 1'b1);
        send_date(14'd1900, 4'd2, 5'd28, 1'b0);
        send_date(14'd2000, 4'd2, 5'd28, 1'b0);
        send_date(14'd2021, 4'd1, 5'd1, 1'b0);
        send_date(14'd2021, 4'd1, 5'd4, 1'b1);
        send_date(14'd2020, 4'd12, 5'd31, 1'b0);
        send_date(14'd2022, 4'd12, 5'd31, 1'b0);
        send_date(14'd2022, 4'd12, 5'd31, 1'b1);
        // stepping back from the first day of year one
        send_date(14'd1, 4'd1, 5'd1, 1'b1);
        send_date(14'd0, 4'd1, 5'd1, 1'b1);
        send_date(14'd0, 4'd0, 5'd0, 1'b0);
        send_date(14'd9999, 4'd12, 5'd31, 1'b0);
        send_date(14'd16383, 4'd12, 5'd31, 1'b0);
        send_date(14'd16383, 4'd15, 5'd31, 1'b1);
        send_date(14'd2023, 4'd13, 5'd31, 1'b0);
        send_date(14'd2023, 4'd14, 5'd0, 1'b1);
        send_date(14'd2023, 4'd2, 5'd31, 1'b0);
        send_date(14'd2024, 4'd2, 5'd30, 1'b1);
        send_date(14'd2023, 4'd4, 5'd31, 1'b0);
        send_date(14'd12000, 4'd2, 5'd29, 1'b0);
        send_date(14'd8191, 4'd8, 5'd16, 1'b1);
    endtask

    task automatic send_random_valid();
        int unsigned special_years [14] = '{1, 2, 3, 4, 99, 100, 399, 400, 1600, 1700,
                                            1900, 2000, 9998, 9999};
        int unsigned y;
        int unsigned m;
        int unsigned len;
        int unsigned d;
        if ($urandom_range(0, 9) < 7)
            y = $urandom_range(1, 9999);
        else
            y = special_years[$urandom_range(0, 13)];
        m = $urandom_range(32'(awds_pkg::MONTH_JAN), 32'(awds_pkg::MONTH_DEC));
        len = month_length(y, m);
        case ($urandom_range(0, 2))
            0:       d = $urandom_range(1, len);
            1:       d = $urandom_range(len - 2, len);
            default: d = $urandom_range(1, 3);
        endcase
        send_date(y[awds_pkg::YEAR_W-1:0], m[awds_pkg::MONTH_W-1:0], d[awds_pkg::DAY_W-1:0],
                  1'($urandom_range(0, 1)));
    endtask

    task automatic send_random_any();
        send_date(14'($urandom_range(0, 16383)), 4'($urandom_range(0, 15)),
                  5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
    endtask

    task automatic test_random_dates();
        repeat (1400)
            send_random_valid();
    endtask

    task automatic test_out_of_range_fields();
        repeat (250)
            send_random_any();
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        repeat (150)
        begin
            if ($urandom_range(0, 4) == 0)
                send_random_any();
            else
                send_random_valid();
        end
    endtask

    initial
    begin
        int waited;
        business_day_t left;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_calendar_edges();
        test_random_dates();
        test_out_of_range_fields();
        test_back_to_back();
        start <= 1'b0;
        waited = 0;
        while (pending_days.size() != 0 && waited < 1000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10)
            @(posedge clk);
        while (pending_days.size() != 0)
        begin
            left = pending_days.pop_front();
            report_mismatch("missing result, year", 0, 32'(left.date.year));
        end
        if (mismatch_count == 0)
            $display("adjacent_weekday_date_stepper test passed");
        else
            $display("adjacent_weekday_date_stepper test failed");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("adjacent_weekday_date_stepper test failed");
        $finish;
    end

endmodule

// ----- adjacent_weekday_date_stepper.f -----
hdl/awds_pkg.sv
hdl/awds_prep.sv
hdl/awds_wday.sv
hdl/awds_step.sv
hdl/adjacent_weekday_date_stepper.sv
hdl/awds_checker.sv
tb/testbench.sv
